@@ design/eau_pkg.sv @@
package eau_pkg;

  // Register file: eight data registers followed by eight address registers.
  localparam int unsigned NUM_REGS = 16;
  localparam int unsigned REG_AW   = 4;

  localparam logic [1:0] CMD_RESOLVE = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_WRITE   = 2'd2;
  localparam logic [1:0] CMD_IGNORE  = 2'd3;

  localparam logic [3:0] MODE_DREG    = 4'd0;
  localparam logic [3:0] MODE_AREG    = 4'd1;
  localparam logic [3:0] MODE_AIND    = 4'd2;
  localparam logic [3:0] MODE_POSTINC = 4'd3;
  localparam logic [3:0] MODE_PREDEC  = 4'd4;
  localparam logic [3:0] MODE_AD16    = 4'd5;
  localparam logic [3:0] MODE_AIDX    = 4'd6;
  localparam logic [3:0] MODE_ABSW    = 4'd7;
  localparam logic [3:0] MODE_ABSL    = 4'd8;
  localparam logic [3:0] MODE_PCD16   = 4'd9;
  localparam logic [3:0] MODE_PCIDX   = 4'd10;
  localparam logic [3:0] MODE_IMM     = 4'd11;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;

  localparam logic [1:0] BUS_NONE  = 2'd0;
  localparam logic [1:0] BUS_READ  = 2'd1;
  localparam logic [1:0] BUS_WRITE = 2'd2;

  localparam logic [2:0] PC_ADV_NONE = 3'd0;
  localparam logic [2:0] PC_ADV_WORD = 3'd2;
  localparam logic [2:0] PC_ADV_LONG = 3'd4;

  localparam logic [2:0] REG_SP = 3'd7;

  localparam int unsigned BRIEF_DA_BIT   = 15;
  localparam int unsigned BRIEF_LONG_BIT = 11;

  localparam logic [31:0] MASK_BYTE = 32'h0000_00FF;
  localparam logic [31:0] MASK_WORD = 32'h0000_FFFF;
  localparam logic [31:0] MASK_LONG = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  mode;
    logic [2:0]  reg_num;
    logic [1:0]  op_size;
    logic [31:0] pc_now;
    logic [15:0] ext_first;
    logic [15:0] ext_second;
    logic [31:0] write_value;
  } eau_in_t;

  typedef struct packed {
    logic [31:0] eff_address;
    logic [31:0] read_value;
    logic [1:0]  bus_action;
    logic [31:0] bus_data;
    logic [2:0]  pc_advance;
  } eau_out_t;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [31:0]       data;
  } eau_wr_t;

endpackage

@@ design/eau_ram.sv @@
module eau_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a_r <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

@@ design/eau_regfile.sv @@
module eau_regfile (
  input  logic                        clk,
  input  logic                        rst_n,
  input  eau_pkg::eau_wr_t            wr,
  input  logic                        re,
  input  logic [eau_pkg::REG_AW-1:0]  raddr_a,
  input  logic [eau_pkg::REG_AW-1:0]  raddr_b,
  output logic [31:0]                 rdata_a,
  output logic [31:0]                 rdata_b
);
  import eau_pkg::*;

  logic [NUM_REGS-1:0] vld_r, vld_nxt;
  logic [1:0]          hit_r, hit_nxt;
  logic [1:0]          ent_vld_r, ent_vld_nxt;
  logic [31:0]         byp_r [2];
  logic [31:0]         byp_nxt [2];
  logic [REG_AW-1:0]   raddr [2];
  logic [31:0]         ram_q [2];

  assign raddr[0] = raddr_a;
  assign raddr[1] = raddr_b;

  eau_ram #(
    .WIDTH (32),
    .DEPTH (NUM_REGS)
  ) u_ram (
    .clk     (clk),
    .we      (wr.en),
    .waddr   (wr.addr),
    .wdata   (wr.data),
    .re_a    (re),
    .raddr_a (raddr_a),
    .rdata_a (ram_q[0]),
    .re_b    (re),
    .raddr_b (raddr_b),
    .rdata_b (ram_q[1])
  );

  // A register never written reads as zero. A read in the same cycle as a
  // write to the same register takes the new value from the bypass.
  always_comb begin
    vld_nxt = vld_r;
    if (wr.en) begin
      vld_nxt[wr.addr] = 1'b1;
    end
    for (int p = 0; p < 2; p++) begin
      hit_nxt[p]     = hit_r[p];
      ent_vld_nxt[p] = ent_vld_r[p];
      byp_nxt[p]     = byp_r[p];
      if (re) begin
        hit_nxt[p]     = wr.en && (wr.addr == raddr[p]);
        ent_vld_nxt[p] = vld_r[raddr[p]];
        byp_nxt[p]     = wr.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      hit_r     <= '0;
      ent_vld_r <= '0;
    end else begin
      vld_r     <= vld_nxt;
      hit_r     <= hit_nxt;
      ent_vld_r <= ent_vld_nxt;
    end
    byp_r[0] <= byp_nxt[0];
    byp_r[1] <= byp_nxt[1];
  end

  assign rdata_a = hit_r[0] ? byp_r[0] : (ent_vld_r[0] ? ram_q[0] : 32'd0);
  assign rdata_b = hit_r[1] ? byp_r[1] : (ent_vld_r[1] ? ram_q[1] : 32'd0);

endmodule

@@ design/eau_calc.sv @@
module eau_calc (
  input  eau_pkg::eau_in_t  item,
  input  logic [31:0]       base_val,
  input  logic [31:0]       index_val,
  output eau_pkg::eau_out_t res,
  output eau_pkg::eau_wr_t  wr
);
  import eau_pkg::*;

  logic        is_byte;
  logic        is_word;
  logic [31:0] mask;
  logic [31:0] step;
  logic [31:0] disp16;
  logic [31:0] disp8;
  logic [31:0] idx;
  logic [31:0] brief_off;
  logic [15:0] e1;

  always_comb begin
    e1      = item.ext_first;
    is_byte = (item.op_size == SIZE_BYTE);
    is_word = (item.op_size == SIZE_WORD);
    mask    = is_byte ? MASK_BYTE : (is_word ? MASK_WORD : MASK_LONG);
    if (is_byte) begin
      step = (item.reg_num == REG_SP) ? 32'd2 : 32'd1;
    end else begin
      step = is_word ? 32'd2 : 32'd4;
    end
    disp16 = {{16{e1[15]}}, e1};
    disp8  = {{24{e1[7]}}, e1[7:0]};
    idx    = e1[BRIEF_LONG_BIT] ? index_val : {{16{index_val[15]}}, index_val[15:0]};
    brief_off = idx + disp8;

    res     = '0;
    wr.en   = 1'b0;
    wr.addr = {1'b1, item.reg_num};
    wr.data = 32'd0;

    if (item.cmd != CMD_IGNORE) begin
      case (item.mode)
        MODE_DREG, MODE_AREG: begin
          if (item.cmd == CMD_READ) begin
            res.read_value = base_val & mask;
          end else if (item.cmd == CMD_WRITE) begin
            wr.en   = 1'b1;
            wr.addr = {item.mode == MODE_AREG, item.reg_num};
            if (item.mode == MODE_DREG) begin
              wr.data = (base_val & ~mask) | (item.write_value & mask);
            end else begin
              wr.data = is_word ? {{16{item.write_value[15]}}, item.write_value[15:0]}
                                : item.write_value;
            end
          end
        end
        MODE_IMM: begin
          if (item.cmd == CMD_READ) begin
            if (!is_byte && !is_word) begin
              res.read_value = {e1, item.ext_second};
              res.pc_advance = PC_ADV_LONG;
            end else begin
              res.read_value = {16'd0, e1} & mask;
              res.pc_advance = PC_ADV_WORD;
            end
          end
        end
        MODE_AIND, MODE_POSTINC, MODE_PREDEC, MODE_AD16, MODE_AIDX,
        MODE_ABSW, MODE_ABSL, MODE_PCD16, MODE_PCIDX: begin
          // Writes through PC-relative modes have no effect at all.
          if (!(item.cmd == CMD_WRITE && (item.mode inside {MODE_PCD16, MODE_PCIDX}))) begin
            case (item.mode)
              MODE_AIND: begin
                res.eff_address = base_val;
              end
              MODE_POSTINC: begin
                res.eff_address = base_val;
                wr.en           = 1'b1;
                wr.data         = base_val + step;
              end
              MODE_PREDEC: begin
                res.eff_address = base_val - step;
                wr.en           = 1'b1;
                wr.data         = base_val - step;
              end
              MODE_AD16: begin
                res.eff_address = base_val + disp16;
                res.pc_advance  = PC_ADV_WORD;
              end
              MODE_AIDX: begin
                res.eff_address = base_val + brief_off;
                res.pc_advance  = PC_ADV_WORD;
              end
              MODE_ABSW: begin
                res.eff_address = disp16;
                res.pc_advance  = PC_ADV_WORD;
              end
              MODE_ABSL: begin
                res.eff_address = {e1, item.ext_second};
                res.pc_advance  = PC_ADV_LONG;
              end
              MODE_PCD16: begin
                res.eff_address = item.pc_now + disp16;
                res.pc_advance  = PC_ADV_WORD;
              end
              MODE_PCIDX: begin
                res.eff_address = item.pc_now + brief_off;
                res.pc_advance  = PC_ADV_WORD;
              end
              default: begin
                res.eff_address = 32'd0;
              end
            endcase
            if (item.cmd == CMD_READ) begin
              res.bus_action = BUS_READ;
            end else if (item.cmd == CMD_WRITE) begin
              res.bus_action = BUS_WRITE;
              res.bus_data   = item.write_value & mask;
            end
          end
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

endmodule

@@ design/effective_address_unit.sv @@
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  eau_in_t  (command, mode, extension words)
// out_      output     out_valid/out_stall  eau_out_t (address, value, bus access)
//
// An accepted item is held in the input stage and its result registered when that
// stage advances; with no output stall, one item can be accepted every cycle. Register
// operands are read from the RAM at acceptance; any register update is written at
// the edge that registers the result. Reset clears the pipeline valids and the
// register valid bits, so every register reads as zero until first written. A stalled
// result holds the output register and in_stall rises once the input stage is full.
module effective_address_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  eau_pkg::eau_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output eau_pkg::eau_out_t out_item
);
  import eau_pkg::*;

  logic     s1_valid_r, s1_valid_nxt;
  eau_in_t  s1_item_r;
  logic     out_valid_r, out_valid_nxt;
  eau_out_t out_item_r;

  logic     out_ready;
  logic     s1_adv;
  logic     in_acc;

  logic [REG_AW-1:0] raddr_a;
  logic [REG_AW-1:0] raddr_b;
  logic [31:0]       base_val;
  logic [31:0]       index_val;
  eau_out_t          calc_res;
  eau_wr_t           calc_wr;
  eau_wr_t           rf_wr;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_acc    = in_valid && !in_stall;

  // Port A fetches the base or direct register, port B the brief-word index.
  assign raddr_a = {in_item.mode != MODE_DREG, in_item.reg_num};
  assign raddr_b = {in_item.ext_first[BRIEF_DA_BIT], in_item.ext_first[14:12]};

  always_comb begin
    rf_wr    = calc_wr;
    rf_wr.en = calc_wr.en && s1_adv;
  end

  eau_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (rf_wr),
    .re      (in_acc),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (base_val),
    .rdata_b (index_val)
  );

  eau_calc u_calc (
    .item      (s1_item_r),
    .base_val  (base_val),
    .index_val (index_val),
    .res       (calc_res),
    .wr        (calc_wr)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_acc) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      out_item_r <= calc_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without an item in the input stage");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("blocked item in the input stage was lost or changed");

  a_no_bus_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.bus_action != BUS_WRITE) |-> (out_item_r.bus_data == 32'd0))
    else $error("bus data present without a memory write");

  a_pc_adv_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.pc_advance == PC_ADV_NONE ||
                     out_item_r.pc_advance == PC_ADV_WORD ||
                     out_item_r.pc_advance == PC_ADV_LONG))
    else $error("illegal extension byte count");
`endif

endmodule
